/* hw/rtl/isrch_pkg.sv */
// shared constants, types and state codes for the interpolation search block
package isrch_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VAL_W       = 32;
  localparam int ADDR_W      = 10;
  localparam int CNT_W       = 11;
  localparam int IDX_W       = ADDR_W + 2;
  localparam int PROD_W      = VAL_W + ADDR_W;
  localparam int QBIT_W      = 4;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUNDS,
    ST_CHECK,
    ST_MULT,
    ST_DIV,
    ST_PROBE,
    ST_COMPARE,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/isrch_ram.sv */
// table memory: one write port, two read ports with registered read data
module isrch_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [WIDTH-1:0]  rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/isrch_div.sv */
// restoring divider, one quotient bit per cycle, quotient below table depth
module isrch_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [isrch_pkg::PROD_W-1:0]      dividend,
  input  logic [isrch_pkg::VAL_W-1:0]       divisor,
  output logic                              done,
  output logic [isrch_pkg::ADDR_W-1:0]      quotient
);

  logic                              busy;
  logic [isrch_pkg::QBIT_W-1:0]      bit_cnt;
  logic [isrch_pkg::PROD_W-1:0]      rem;
  logic [isrch_pkg::VAL_W-1:0]       dsor;
  logic [isrch_pkg::PROD_W-1:0]      shifted;
  logic                              fits;

  // trial subtract of the divisor aligned to the current quotient bit
  always_comb begin
    shifted = isrch_pkg::PROD_W'(dsor) << bit_cnt;
    fits    = (rem >= shifted);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bit_cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsor     <= divisor;
      quotient <= '0;
      bit_cnt  <= isrch_pkg::QBIT_W'(isrch_pkg::ADDR_W - 1);
    end else if (busy) begin
      if (fits) begin
        rem               <= rem - shifted;
        quotient[bit_cnt] <= 1'b1;
      end
      if (bit_cnt != '0) begin
        bit_cnt <= bit_cnt - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/interpolation_search.sv */
// top level: interpolation search over a sorted table held in block memory
//
// Requests arrive on in_valid/in_ready. opcode OP_WRITE stores write_value at
// write_index when it is taken and gives no result; OP_SEARCH looks for
// search_key among entries 0 to element_count-1 and gives one result on
// out_valid/out_ready (found, found_index, probe_count).
// element_count is written through cfg_wen/cfg_wdata, only while the block is
// idle: the user must keep to this, the block does not enforce it; values
// above the table depth act as the full depth. In a search each probe reads
// both range ends from the dual-read table memory, forms a 10x32 product and
// runs a restoring divide (not if the ends match), then reads the probed entry.
// One request is in work at a time; in_ready is high only while idle.
// The result sits in an output register, so a new request is taken while it
// waits; a finished search holds until that register is free.
// Synchronous reset clears the controller, the output valid and sets
// element_count to 1; table contents are undefined until written.
module interpolation_search (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [isrch_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [isrch_pkg::ADDR_W-1:0]    write_index,
  input  logic signed [isrch_pkg::VAL_W-1:0] write_value,
  input  logic signed [isrch_pkg::VAL_W-1:0] search_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [isrch_pkg::ADDR_W-1:0]    found_index,
  output logic [isrch_pkg::CNT_W-1:0]     probe_count
);

  isrch_pkg::state_t state, state_next;

  logic [isrch_pkg::CNT_W-1:0]            element_count;
  logic [isrch_pkg::CNT_W-1:0]            count_eff;
  logic signed [isrch_pkg::IDX_W-1:0]     lo;
  logic signed [isrch_pkg::IDX_W-1:0]     hi;
  logic signed [isrch_pkg::VAL_W-1:0]     key;
  logic [isrch_pkg::CNT_W-1:0]            probes;
  logic                                   hit;
  logic [isrch_pkg::ADDR_W-1:0]           at;
  logic [isrch_pkg::ADDR_W-1:0]           pos;
  logic [isrch_pkg::VAL_W-1:0]            num;
  logic [isrch_pkg::VAL_W-1:0]            den;
  logic [isrch_pkg::ADDR_W-1:0]           span;

  logic                                   ram_we;
  logic [isrch_pkg::ADDR_W-1:0]           raddr_a;
  logic [isrch_pkg::VAL_W-1:0]            rdata_a;
  logic [isrch_pkg::VAL_W-1:0]            rdata_b;
  logic signed [isrch_pkg::VAL_W-1:0]     ta;
  logic signed [isrch_pkg::VAL_W-1:0]     tb;

  logic                                   div_start;
  logic                                   div_done;
  logic [isrch_pkg::ADDR_W-1:0]           quotient;
  logic [isrch_pkg::PROD_W-1:0]           product;

  logic                                   in_fire;
  logic                                   range_ok;
  logic                                   key_in;
  logic                                   out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= isrch_pkg::CNT_W'(1);
    end else if (cfg_wen) begin
      element_count <= cfg_wdata;
    end
  end

  // table memory
  isrch_ram #(
    .DEPTH  (isrch_pkg::TABLE_DEPTH),
    .WIDTH  (isrch_pkg::VAL_W),
    .ADDR_W (isrch_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (write_index),
    .wdata   (write_value),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (hi[isrch_pkg::ADDR_W-1:0]),
    .rdata_b (rdata_b)
  );

  // probe position divider
  isrch_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // shared conditions
  always_comb begin
    count_eff = (element_count > isrch_pkg::CNT_W'(isrch_pkg::TABLE_DEPTH))
                ? isrch_pkg::CNT_W'(isrch_pkg::TABLE_DEPTH) : element_count;
    ta        = signed'(rdata_a);
    tb        = signed'(rdata_b);
    range_ok  = (lo <= hi) && !hi[isrch_pkg::IDX_W-1];
    key_in    = (key >= ta) && (key <= tb);
    out_free  = !out_valid || out_ready;
    in_fire   = in_valid && in_ready;
    product   = isrch_pkg::PROD_W'(span) * isrch_pkg::PROD_W'(num);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      isrch_pkg::ST_IDLE: begin
        if (in_valid && (opcode == isrch_pkg::OP_SEARCH)) begin
          state_next = isrch_pkg::ST_BOUNDS;
        end
      end
      isrch_pkg::ST_BOUNDS: begin
        state_next = range_ok ? isrch_pkg::ST_CHECK : isrch_pkg::ST_DONE;
      end
      isrch_pkg::ST_CHECK: begin
        if (!key_in || (lo == hi)) begin
          state_next = isrch_pkg::ST_DONE;
        end else if (ta == tb) begin
          state_next = isrch_pkg::ST_PROBE;
        end else begin
          state_next = isrch_pkg::ST_MULT;
        end
      end
      isrch_pkg::ST_MULT: begin
        state_next = isrch_pkg::ST_DIV;
      end
      isrch_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = isrch_pkg::ST_PROBE;
        end
      end
      isrch_pkg::ST_PROBE: begin
        state_next = isrch_pkg::ST_COMPARE;
      end
      isrch_pkg::ST_COMPARE: begin
        state_next = (ta == key) ? isrch_pkg::ST_DONE : isrch_pkg::ST_BOUNDS;
      end
      isrch_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = isrch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = isrch_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    raddr_a   = lo[isrch_pkg::ADDR_W-1:0];
    case (state)
      isrch_pkg::ST_IDLE:  in_ready  = 1'b1;
      isrch_pkg::ST_MULT:  div_start = 1'b1;
      isrch_pkg::ST_PROBE: raddr_a   = pos;
      default: begin
        in_ready = 1'b0;
      end
    endcase
    ram_we = in_fire && (opcode == isrch_pkg::OP_WRITE);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isrch_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      isrch_pkg::ST_IDLE: begin
        lo     <= '0;
        hi     <= signed'({1'b0, count_eff}) - isrch_pkg::IDX_W'(1);
        key    <= search_key;
        probes <= '0;
        hit    <= 1'b0;
        at     <= '0;
      end
      isrch_pkg::ST_CHECK: begin
        span <= isrch_pkg::ADDR_W'(hi - lo);
        num  <= isrch_pkg::VAL_W'(key - ta);
        den  <= isrch_pkg::VAL_W'(tb - ta);
        pos  <= lo[isrch_pkg::ADDR_W-1:0];
        if (key_in) begin
          probes <= probes + 1'b1;
          if ((lo == hi) && (ta == key)) begin
            hit <= 1'b1;
            at  <= lo[isrch_pkg::ADDR_W-1:0];
          end
        end
      end
      isrch_pkg::ST_DIV: begin
        if (div_done) begin
          pos <= lo[isrch_pkg::ADDR_W-1:0] + quotient;
        end
      end
      isrch_pkg::ST_COMPARE: begin
        if (ta == key) begin
          hit <= 1'b1;
          at  <= pos;
        end else if (ta < key) begin
          lo <= signed'({2'b00, pos}) + isrch_pkg::IDX_W'(1);
        end else begin
          hi <= signed'({2'b00, pos}) - isrch_pkg::IDX_W'(1);
        end
      end
      default: begin
        span <= span;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == isrch_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == isrch_pkg::ST_DONE) && out_free) begin
      found       <= hit;
      found_index <= hit ? at : '0;
      probe_count <= probes;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// testbench for the interpolation search block: shadow table, random requests and stalls
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_TAIL   = 24;
  localparam int RANDOM_ITEMS = 60;
  localparam int HOLD_CYCLES  = 500;

  localparam logic signed [isrch_pkg::VAL_W-1:0] VAL_MIN =
    {1'b1, {(isrch_pkg::VAL_W-1){1'b0}}};
  localparam logic signed [isrch_pkg::VAL_W-1:0] VAL_MAX =
    {1'b0, {(isrch_pkg::VAL_W-1){1'b1}}};

  typedef struct packed {
    logic                         found;
    logic [isrch_pkg::ADDR_W-1:0] index;
    logic [isrch_pkg::CNT_W-1:0]  probes;
  } search_result_t;

  typedef enum int {
    FILL_SPREAD,
    FILL_CLUSTERED,
    FILL_FLAT,
    FILL_SKEWED
  } fill_shape_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_wen;
  logic [isrch_pkg::CNT_W-1:0]         cfg_wdata;
  logic                                in_valid;
  logic                                in_ready;
  logic                                opcode;
  logic [isrch_pkg::ADDR_W-1:0]        write_index;
  logic signed [isrch_pkg::VAL_W-1:0]  write_value;
  logic signed [isrch_pkg::VAL_W-1:0]  search_key;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic                                found;
  logic [isrch_pkg::ADDR_W-1:0]        found_index;
  logic [isrch_pkg::CNT_W-1:0]         probe_count;

  // shadow copy of the table and the count register
  logic signed [isrch_pkg::VAL_W-1:0]  shadow_entries [isrch_pkg::TABLE_DEPTH];
  logic [isrch_pkg::CNT_W-1:0]         shadow_count;
  search_result_t                      predicted [int unsigned];
  search_result_t                      next_answer;
  int unsigned                         searches_sent;
  int unsigned                         searches_checked;

  int unsigned              failures;
  int unsigned              requests_sent;
  int unsigned              burst_left;
  int unsigned              cycle_count;
  bit                       hold_off_go;
  bit                       hold_taken;
  int unsigned              hold_left;
  int unsigned              stall_tick;
  int unsigned              stall_mode;

  interpolation_search u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .write_index (write_index),
    .write_value (write_value),
    .search_key  (search_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .found_index (found_index),
    .probe_count (probe_count)
  );

  always #1 clk = ~clk;

  // interpolation search over the shadow table
  function automatic search_result_t interpolate_lookup(
    input logic signed [isrch_pkg::VAL_W-1:0] key);
    search_result_t ans;
    longint kv, lv, hv, tv, lo, hi, pos;
    ans = '0;
    kv = longint'(key);
    lo = 0;
    hi = (int'(shadow_count) > isrch_pkg::TABLE_DEPTH)
         ? longint'(isrch_pkg::TABLE_DEPTH - 1) : longint'(shadow_count) - 1;
    while (lo <= hi && hi >= 0) begin
      lv = longint'(shadow_entries[lo]);
      hv = longint'(shadow_entries[hi]);
      if (kv < lv || kv > hv) break;
      ans.probes = ans.probes + 1'b1;
      // range down to one entry
      if (lo == hi) begin
        if (lv == kv) begin
          ans.found = 1'b1;
          ans.index = lo[isrch_pkg::ADDR_W-1:0];
        end
        break;
      end
      // equal corners probe the low end
      if (hv == lv) pos = lo;
      else pos = lo + (hi - lo) * (kv - lv) / (hv - lv);
      tv = longint'(shadow_entries[pos]);
      if (tv == kv) begin
        ans.found = 1'b1;
        ans.index = pos[isrch_pkg::ADDR_W-1:0];
        break;
      end
      if (tv < kv) lo = pos + 1;
      else hi = pos - 1;
    end
    return ans;
  endfunction

  // key near the live entries, outside them, or anywhere
  function automatic logic signed [isrch_pkg::VAL_W-1:0] pick_key(input int n);
    int unsigned i;
    longint k;
    if (n == 0) return int'($urandom());
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0, 1, 2: k = longint'(shadow_entries[i]);
      3:       k = longint'(shadow_entries[i]) + 1;
      4:       k = longint'(shadow_entries[i]) - 1;
      5:       k = longint'(shadow_entries[0]) - longint'($urandom_range(1, 1000));
      6:       k = longint'(shadow_entries[n-1]) + longint'($urandom_range(1, 1000));
      default: k = longint'(int'($urandom()));
    endcase
    return k[isrch_pkg::VAL_W-1:0];
  endfunction

  // offer one request in bursts with random gaps, then update the shadow state
  task automatic send_request(input logic op, input logic [isrch_pkg::ADDR_W-1:0] idx,
                              input logic signed [isrch_pkg::VAL_W-1:0] val,
                              input logic signed [isrch_pkg::VAL_W-1:0] key);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    opcode      <= op;
    write_index <= idx;
    write_value <= val;
    search_key  <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (op == isrch_pkg::OP_WRITE) begin
      shadow_entries[idx] = val;
    end else begin
      predicted[searches_sent] = interpolate_lookup(key);
      searches_sent++;
    end
  endtask

  task automatic write_entry(input int idx, input logic signed [isrch_pkg::VAL_W-1:0] val);
    send_request(isrch_pkg::OP_WRITE, isrch_pkg::ADDR_W'(idx), val, $urandom());
  endtask

  task automatic search_for(input logic signed [isrch_pkg::VAL_W-1:0] key);
    send_request(isrch_pkg::OP_SEARCH,
                 isrch_pkg::ADDR_W'($urandom_range(0, isrch_pkg::TABLE_DEPTH - 1)),
                 $urandom(), key);
  endtask

  // stop offering until every search has answered and the last write has landed
  task automatic settle_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (searches_checked != searches_sent) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    settle_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= isrch_pkg::CNT_W'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow_count = isrch_pkg::CNT_W'(value);
  endtask

  // fill entries 0..n-1 in ascending order with the chosen spacing
  task automatic load_sorted_run(input int n, input fill_shape_t shape);
    longint level, step;
    int unsigned step_cap;
    int i;
    step_cap = 32'hffff_ffff / n;
    if (shape == FILL_SPREAD) level = longint'(VAL_MIN) + longint'($urandom_range(0, 1 << 20));
    else level = longint'(int'($urandom()));
    for (i = 0; i < n; i++) begin
      write_entry(i, level[isrch_pkg::VAL_W-1:0]);
      case (shape)
        FILL_SPREAD:    step = longint'($urandom_range(0, step_cap));
        FILL_CLUSTERED: step = longint'($urandom_range(0, 2));
        FILL_FLAT:      step = 0;
        default:        step = (longint'(1) << (i < 30 ? i : 30)) +
                               longint'($urandom_range(0, 1));
      endcase
      level = level + step;
      if (level > longint'(VAL_MAX)) level = longint'(VAL_MAX);
    end
  endtask

  task automatic test_directed();
    logic signed [isrch_pkg::VAL_W-1:0] ladder [8];
    int i;
    ladder = '{VAL_MIN, -5, -5, 0, 7, 100, 1000, VAL_MAX};
    // empty table
    write_count(0);
    search_for(0);
    for (i = 0; i < 8; i++) write_entry(i, ladder[i]);
    // single entry
    write_count(1);
    search_for(VAL_MIN);
    search_for(3);
    // duplicates and both value extremes
    write_count(8);
    search_for(VAL_MAX);
    search_for(100);
    search_for(50);
    search_for(-5);
    search_for(VAL_MIN);
    // flat range
    for (i = 0; i < 4; i++) write_entry(i, 42);
    write_count(4);
    search_for(42);
    search_for(41);
    // entries out of order
    write_entry(2, 10);
    write_entry(3, 60);
    search_for(50);
  endtask

  task automatic test_full_table();
    write_count(isrch_pkg::TABLE_DEPTH);
    load_sorted_run(isrch_pkg::TABLE_DEPTH, FILL_SPREAD);
    repeat (12) search_for(pick_key(isrch_pkg::TABLE_DEPTH));
    // counts beyond the depth act as the full table
    write_count(2047);
    repeat (4) search_for(pick_key(isrch_pkg::TABLE_DEPTH));
    write_count(isrch_pkg::TABLE_DEPTH + 1);
    repeat (2) search_for(pick_key(isrch_pkg::TABLE_DEPTH));
  endtask

  task automatic test_random_rounds();
    int unsigned start_sent, pick, span_n, searches;
    logic [isrch_pkg::CNT_W-1:0] count;
    start_sent = requests_sent;
    while (requests_sent - start_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) count = '0;
      else if (pick < 9)
        count = $urandom_range(0, 1) ? isrch_pkg::CNT_W'(isrch_pkg::TABLE_DEPTH)
                                     : isrch_pkg::CNT_W'($urandom_range(1025, 2047));
      else if (pick < 30) count = isrch_pkg::CNT_W'($urandom_range(17, 48));
      else count = isrch_pkg::CNT_W'($urandom_range(1, 16));
      span_n = (int'(count) > isrch_pkg::TABLE_DEPTH) ? isrch_pkg::TABLE_DEPTH : int'(count);
      write_count(int'(count));
      // small tables get fresh sorted contents, the full one keeps what it has
      if (span_n != 0 && span_n < isrch_pkg::TABLE_DEPTH)
        load_sorted_run(span_n, fill_shape_t'($urandom_range(0, 3)));
      searches = (span_n == isrch_pkg::TABLE_DEPTH) ? 4 : $urandom_range(4, 20);
      repeat (searches) begin
        // stray writes scramble the order now and then
        if ($urandom_range(0, 9) == 0)
          write_entry($urandom_range(0, isrch_pkg::TABLE_DEPTH - 1), $urandom());
        search_for(pick_key(span_n));
      end
    end
  endtask

  task automatic test_backpressure();
    write_count(16);
    load_sorted_run(16, FILL_SPREAD);
    // receiver holds off while searches keep coming back to back
    hold_off_go = 1'b1;
    burst_left = 32;
    repeat (12) search_for(pick_key(16));
    settle_idle();
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_off_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (stall_tick % 5 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare each result with the oldest predicted answer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (searches_checked == searches_sent) begin
        $error("result with no search outstanding");
        failures++;
      end else begin
        next_answer = predicted[searches_checked];
        if (found !== next_answer.found) begin
          $error("found: expected %0d, got %0d", next_answer.found, found);
          failures++;
        end
        if (found_index !== next_answer.index) begin
          $error("found_index: expected %0d, got %0d", next_answer.index, found_index);
          failures++;
        end
        if (probe_count !== next_answer.probes) begin
          $error("probe_count: expected %0d, got %0d", next_answer.probes, probe_count);
          failures++;
        end
        searches_checked++;
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    cfg_wen      = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    opcode       = isrch_pkg::OP_WRITE;
    write_index  = '0;
    write_value  = '0;
    search_key   = '0;
    shadow_count = isrch_pkg::CNT_W'(1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random_rounds();
    test_backpressure();
    settle_idle();
    if (failures == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
